/* hdl/lc3se_pkg.sv */
// Shared types and constants for the LC-3 subset execute block.
// Holds opcode values, the decoded queue item and the queue status struct.
// No dependencies.
package lc3se_pkg;

    localparam int MEM_DEPTH = 65536;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [3:0] OPC_BR  = 4'h0;
    localparam logic [3:0] OPC_ADD = 4'h1;
    localparam logic [3:0] OPC_LD  = 4'h2;
    localparam logic [3:0] OPC_LDR = 4'h6;
    localparam logic [3:0] OPC_STR = 4'h7;

    typedef logic [15:0] t_word;
    typedef logic signed [1:0] t_cond;

    localparam t_cond COND_NEG  = 2'sb11;
    localparam t_cond COND_ZERO = 2'sb00;
    localparam t_cond COND_POS  = 2'sb01;

    typedef enum logic [2:0] {
        OP_MEMW,
        OP_ADD,
        OP_LD,
        OP_LDR,
        OP_BR,
        OP_STR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] dr;
        logic [2:0] ra;
        logic [2:0] rb;
        logic       use_imm;
        logic       br_p;
        t_word      imm;
        t_word      location;
        t_word      word;
        t_word      target;
    } t_qitem;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

/* hdl/lc3se_front.sv */
// Front end: accepts input items and classifies them into decoded queue items.
// Computes immediates and the PC-relative target ahead of execution.
// Depends on lc3se_pkg.
module lc3se_front (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [15:0]       i_location,
    input  logic [15:0]       i_word_bits,
    input  lc3se_pkg::t_qstat i_q_stat,
    output logic              o_q_push,
    output lc3se_pkg::t_qitem o_q_item
);
    import lc3se_pkg::*;

    logic [3:0] opc;
    t_word      sext5;
    t_word      sext6;
    t_word      sext9;

    assign opc   = i_word_bits[15:12];
    assign sext5 = {{11{i_word_bits[4]}}, i_word_bits[4:0]};
    assign sext6 = {{10{i_word_bits[5]}}, i_word_bits[5:0]};
    assign sext9 = {{7{i_word_bits[8]}}, i_word_bits[8:0]};

    always_comb begin
        o_q_item          = '0;
        o_q_item.location = i_location;
        o_q_item.word     = i_word_bits;
        o_q_item.dr       = i_word_bits[11:9];
        o_q_item.ra       = i_word_bits[8:6];
        o_q_item.rb       = i_word_bits[2:0];
        o_q_item.br_p     = i_word_bits[9];
        o_q_item.use_imm  = 1'b0;
        o_q_item.imm      = sext6;
        o_q_item.target   = i_location + sext9;
        o_q_item.op       = OP_NOP;
        if (!i_req_type) begin
            o_q_item.op = OP_MEMW;
        end else begin
            unique case (opc)
                OPC_ADD: begin
                    o_q_item.op      = OP_ADD;
                    o_q_item.use_imm = i_word_bits[5];
                    o_q_item.imm     = sext5;
                end
                OPC_LD: begin
                    o_q_item.op = OP_LD;
                end
                OPC_LDR: begin
                    o_q_item.op      = OP_LDR;
                    o_q_item.use_imm = 1'b1;
                end
                OPC_BR: begin
                    o_q_item.op = OP_BR;
                end
                OPC_STR: begin
                    // second read port fetches the source register
                    o_q_item.op      = OP_STR;
                    o_q_item.use_imm = 1'b1;
                    o_q_item.rb      = i_word_bits[11:9];
                end
                default: begin
                    o_q_item.op = OP_NOP;
                end
            endcase
        end
    end

    assign o_in_ready = !i_q_stat.full;
    assign o_q_push   = i_in_valid && !i_q_stat.full;

endmodule

/* hdl/lc3se_queue.sv */
// Short FIFO of decoded items between the front end and the execute unit.
// Depth set by Q_DEPTH.
// Depends on lc3se_pkg.
module lc3se_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lc3se_pkg::t_qitem i_item,
    input  logic              i_pop,
    output lc3se_pkg::t_qitem o_item,
    output lc3se_pkg::t_qstat o_stat
);
    import lc3se_pkg::*;

    t_qitem          r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_count;
    logic [Q_AW-1:0] n_wr;
    logic [Q_AW-1:0] n_rd;
    logic            do_push;
    logic            do_pop;

    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_item       = r_slot[r_rd];

    assign n_wr = (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

endmodule

/* hdl/lc3se_back.sv */
// Execute unit: register file, condition, word memory and result register.
// Takes decoded items from the queue; loads finish after a registered read of the word memory.
// Depends on lc3se_pkg.
module lc3se_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lc3se_pkg::t_qitem i_q_item,
    input  lc3se_pkg::t_qstat i_q_stat,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [15:0]       o_next_pc,
    output logic signed [1:0] o_cond_code,
    output logic              o_store_valid,
    output logic [15:0]       o_store_addr,
    output logic signed [15:0] o_store_data
);
    import lc3se_pkg::*;

    function automatic t_cond cond_of(input t_word v);
        t_cond c;
        if (v[15]) begin
            c = COND_NEG;
        end else if (v == '0) begin
            c = COND_ZERO;
        end else begin
            c = COND_POS;
        end
        return c;
    endfunction

    t_word  r_rf [8];
    t_cond  r_cond;
    t_word  r_mem [MEM_DEPTH];
    t_word  r_mem_q;
    logic   r_x_valid;
    t_qitem r_x;
    t_word  r_x_a;
    t_word  r_x_b;
    logic   r_ld_wait;
    logic   r_out_valid;
    t_word  r_out_pc;
    t_cond  r_out_cond;
    logic   r_out_sv;
    t_word  r_out_sa;
    t_word  r_out_sd;

    logic   out_free;
    logic   is_load;
    t_word  sum;
    t_word  ld_addr;
    logic   x_issue;
    logic   x_fin;
    logic   x_take;
    logic   pop;
    logic   wr_en;
    t_word  wr_val;
    t_cond  cond_after;
    t_word  rd_a;
    t_word  rd_b;
    t_word  res_pc;
    logic   res_sv;
    t_word  res_sa;
    t_word  res_sd;

    assign out_free = !r_out_valid || i_out_ready;
    assign is_load  = (r_x.op == OP_LD) || (r_x.op == OP_LDR);
    assign sum      = r_x_a + (r_x.use_imm ? r_x.imm : r_x_b);
    assign ld_addr  = (r_x.op == OP_LD) ? r_x.target : sum;
    assign x_issue  = r_x_valid && is_load && !r_ld_wait;
    assign x_fin    = r_x_valid && out_free && (!is_load || r_ld_wait);
    assign x_take   = !r_x_valid || x_fin;
    assign pop      = x_take && !i_q_stat.empty;
    assign o_q_pop  = pop;

    assign wr_en      = x_fin && ((r_x.op == OP_ADD) || is_load);
    assign wr_val     = is_load ? r_mem_q : sum;
    assign cond_after = wr_en ? cond_of(wr_val) : r_cond;

    // forward the value being written back this cycle to the next item's reads
    assign rd_a = (wr_en && (r_x.dr == i_q_item.ra)) ? wr_val : r_rf[i_q_item.ra];
    assign rd_b = (wr_en && (r_x.dr == i_q_item.rb)) ? wr_val : r_rf[i_q_item.rb];

    always_comb begin
        res_pc = r_x.location;
        res_sv = 1'b0;
        res_sa = '0;
        res_sd = '0;
        unique case (r_x.op)
            OP_MEMW: begin
                res_pc = '0;
            end
            OP_BR: begin
                if (r_x.br_p && (r_cond == COND_POS)) begin
                    res_pc = r_x.target;
                end
            end
            OP_STR: begin
                res_sv = 1'b1;
                res_sa = sum;
                res_sd = r_x_b;
            end
            default: begin
                res_pc = r_x.location;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid   <= 1'b0;
            r_ld_wait   <= 1'b0;
            r_out_valid <= 1'b0;
            r_cond      <= COND_ZERO;
            for (int i = 0; i < 8; i++) begin
                r_rf[i] <= '0;
            end
        end else begin
            if (x_take) begin
                r_x_valid <= pop;
            end
            if (x_issue) begin
                r_ld_wait <= 1'b1;
            end else if (x_fin) begin
                r_ld_wait <= 1'b0;
            end
            if (x_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (wr_en) begin
                r_rf[r_x.dr] <= wr_val;
            end
            r_cond <= cond_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_x   <= i_q_item;
            r_x_a <= rd_a;
            r_x_b <= rd_b;
        end
        if (x_fin) begin
            r_out_pc   <= res_pc;
            r_out_cond <= cond_after;
            r_out_sv   <= res_sv;
            r_out_sa   <= res_sa;
            r_out_sd   <= res_sd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (x_fin && (r_x.op == OP_MEMW)) begin
            r_mem[r_x.location[MEM_AW-1:0]] <= r_x.word;
        end
        if (x_issue) begin
            r_mem_q <= r_mem[ld_addr[MEM_AW-1:0]];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_next_pc     = r_out_pc;
    assign o_cond_code   = r_out_cond;
    assign o_store_valid = r_out_sv;
    assign o_store_addr  = r_out_sa;
    assign o_store_data  = signed'(r_out_sd);

endmodule

/* hdl/lc3_subset_execute.sv */
// Top level of the LC-3 subset execute block: front end, item queue, execute unit.
// Depends on lc3se_pkg, lc3se_front, lc3se_queue and lc3se_back.
//
//   channel | handshake                 | payload
//   --------+---------------------------+---------------------------------------------
//   in      | i_in_valid / o_in_ready   | i_req_type, i_location, i_word_bits
//   out     | o_out_valid / i_out_ready | o_next_pc, o_cond_code, o_store_valid,
//           |                           | o_store_addr, o_store_data
//
// ADD, BR, STR, unsupported opcodes and memory writes finish without a memory wait in the
// execute stage; LD and LDR first issue a registered read of the single-port word memory.
// The front end accepts one item per cycle while the 2-entry queue has room; an
// accepted item passes through a queue slot, the execute register and the result register.
// Reset clears registers, condition, queue pointers and the result valid flag; the word
// memory is not cleared. A stalled output holds the result and backs up the queue and then the input.
module lc3_subset_execute (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_req_type,
    input  logic [15:0]        i_location,
    input  logic [15:0]        i_word_bits,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_next_pc,
    output logic signed [1:0]  o_cond_code,
    output logic               o_store_valid,
    output logic [15:0]        o_store_addr,
    output logic signed [15:0] o_store_data
);
    import lc3se_pkg::*;

    t_qitem q_in_item;
    t_qitem q_out_item;
    t_qstat q_stat;
    logic   q_push;
    logic   q_pop;

    lc3se_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_location  (i_location),
        .i_word_bits (i_word_bits),
        .i_q_stat    (q_stat),
        .o_q_push    (q_push),
        .o_q_item    (q_in_item)
    );

    lc3se_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .i_pop   (q_pop),
        .o_item  (q_out_item),
        .o_stat  (q_stat)
    );

    lc3se_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_item      (q_out_item),
        .i_q_stat      (q_stat),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_next_pc     (o_next_pc),
        .o_cond_code   (o_cond_code),
        .o_store_valid (o_store_valid),
        .o_store_addr  (o_store_addr),
        .o_store_data  (o_store_data)
    );

`ifndef SYNTH
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("execute unit popped an empty queue");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("front end pushed into a full queue");

    a_cond_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cond_code != 2'sb10))
        else $error("result carries an illegal condition code");
`endif

endmodule
